// ----- rtl/mwm_pkg.sv -----
// Package for the mecanum wheel speed mixer: register indexes, reset values,
// pipeline stage types and helpers. No dependencies.
package mwm_pkg;

  typedef enum logic [2:0] {
    REG_MAX_SIDEWAYS = 3'd0,
    REG_MAX_FORWARD  = 3'd1,
    REG_MAX_TURN     = 3'd2,
    REG_FRONT_ROT    = 3'd3,
    REG_REAR_ROT     = 3'd4,
    REG_RPM_RATIO    = 3'd5,
    REG_MAX_WHEEL    = 3'd6
  } cfg_idx_t;

  localparam logic [14:0] RST_MAX_SIDEWAYS = 15'd3300;
  localparam logic [14:0] RST_MAX_FORWARD  = 15'd3300;
  localparam logic [14:0] RST_MAX_TURN     = 15'd300;
  localparam logic [31:0] RST_FRONT_ROT    = 32'd524288;
  localparam logic [31:0] RST_REAR_ROT     = 32'd524288;
  localparam logic [31:0] RST_RPM_RATIO    = 32'd110833;
  localparam logic [14:0] RST_MAX_WHEEL    = 15'd8500;

  localparam int QW = 15;   // quotient bits of the scaling divider
  localparam int NW = 31;   // numerator bits: |wheel| * limit

  typedef struct packed {
    logic [3:0][NW-1:0] rem;
    logic [3:0][QW-1:0] quo;
    logic [3:0][15:0]   w;
    logic [3:0]         neg;
    logic [15:0]        largest;
    logic               limited;
  } div_t;

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [16:0] e;
    e = v[15] ? 17'(-$signed({v[15], v})) : 17'({1'b0, v});
    return e[15:0];
  endfunction

endpackage

// ----- rtl/mwm_if.sv -----
// Handshake channels of the mixer: chassis command and wheel speed words.
// Depends on nothing.
interface mwm_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sideways_speed;
  logic signed [15:0] forward_speed;
  logic signed [15:0] turn_rate;
  modport source (output valid, sideways_speed, forward_speed, turn_rate, input ready);
  modport sink   (input valid, sideways_speed, forward_speed, turn_rate, output ready);
endinterface

interface mwm_rpm_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] right_front_rpm;
  logic signed [15:0] left_front_rpm;
  logic signed [15:0] left_rear_rpm;
  logic signed [15:0] right_rear_rpm;
  logic               speed_limited;
  modport source (output valid, right_front_rpm, left_front_rpm, left_rear_rpm,
                  right_rear_rpm, speed_limited, input ready);
  modport sink   (input valid, right_front_rpm, left_front_rpm, left_rear_rpm,
                  right_rear_rpm, speed_limited, output ready);
endinterface

// ----- rtl/mecanum_wheel_speed_mixer.sv -----
// Mecanum inverse kinematics: clamp, mix, rpm scale, saturate, limit scaling.
// Depends on mwm_pkg and the channel interfaces in mwm_if.sv.
// Throughput: one word per cycle; the 15-stage restoring divider of the
// limit scaling sets the depth. The whole pipe stalls while the output waits.
// Reset (synchronous, rst_n low) clears all valid bits and loads register defaults.
module mecanum_wheel_speed_mixer
  import mwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mwm_cmd_if.sink     in_cmd,
  mwm_rpm_if.source   out_rpm,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [14:0] max_x_r, max_y_r, max_w_r, lim_r;
  logic signed [31:0] front_r, rear_r;
  logic [31:0] ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r <= RST_MAX_SIDEWAYS;
      max_y_r <= RST_MAX_FORWARD;
      max_w_r <= RST_MAX_TURN;
      front_r <= RST_FRONT_ROT;
      rear_r  <= RST_REAR_ROT;
      ratio_r <= RST_RPM_RATIO;
      lim_r   <= RST_MAX_WHEEL;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_MAX_SIDEWAYS: max_x_r <= cfg_wdata[14:0];
        REG_MAX_FORWARD:  max_y_r <= cfg_wdata[14:0];
        REG_MAX_TURN:     max_w_r <= cfg_wdata[14:0];
        REG_FRONT_ROT:    front_r <= cfg_wdata;
        REG_REAR_ROT:     rear_r  <= cfg_wdata;
        REG_RPM_RATIO:    ratio_r <= cfg_wdata;
        REG_MAX_WHEEL:    lim_r   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  localparam int NST = 6;
  logic [NST-1:0] v_r;
  logic           out_v_r;
  logic           en;

  assign en           = !out_v_r || out_rpm.ready;
  assign in_cmd.ready = en;

  // stage 1: clamp
  function automatic logic signed [15:0] clamp(input logic signed [15:0] v,
                                               input logic [14:0] m);
    logic signed [16:0] e, p;
    e = 17'(v);
    p = $signed({2'b00, m});
    if (e > p)       return 16'(p);
    else if (e < -p) return 16'(-p);
    else             return v;
  endfunction

  logic signed [15:0] cx_r, cy_r, cw_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r <= clamp(in_cmd.sideways_speed, max_x_r);
      cy_r <= clamp(in_cmd.forward_speed, max_y_r);
      cw_r <= clamp(in_cmd.turn_rate, max_w_r);
    end
  end

  // stage 2: turn terms
  logic signed [15:0] x2_r, y2_r;
  logic signed [47:0] tf_r, tr_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x2_r <= cx_r;
      y2_r <= cy_r;
      tf_r <= 48'(cw_r) * 48'(front_r);
      tr_r <= 48'(cw_r) * 48'(rear_r);
    end
  end

  // stage 3: wheel sums and magnitudes
  logic signed [49:0] vx50, vy50, tf50, tr50;
  logic signed [49:0] s [4];
  logic [3:0][49:0] m_r;
  logic [3:0]       n3_r;
  assign vx50 = 50'(x2_r) <<< 16;
  assign vy50 = 50'(y2_r) <<< 16;
  assign tf50 = 50'(tf_r);
  assign tr50 = 50'(tr_r);
  assign s[0] = -vx50 - vy50 + tf50;
  assign s[1] =  vx50 - vy50 + tf50;
  assign s[2] =  vx50 + vy50 + tr50;
  assign s[3] = -vx50 + vy50 + tr50;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        m_r[i]  <= s[i][49] ? 50'(-s[i]) : 50'(s[i]);
        n3_r[i] <= s[i][49];
      end
    end
  end

  // stage 4: rpm ratio partial products
  logic [3:0][57:0] pa_r;
  logic [3:0][55:0] pb_r;
  logic [3:0]       n4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        pa_r[i] <= 58'(m_r[i][49:24]) * 58'(ratio_r);
        pb_r[i] <= 56'(m_r[i][23:0]) * 56'(ratio_r);
      end
      n4_r <= n3_r;
    end
  end

  // stage 5: truncate and saturate
  logic [3:0][15:0] w5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        logic [57:0] x;
        logic [41:0] q;
        x = pa_r[i] + 58'(pb_r[i] >> 24);
        q = x[57:16];
        if (n4_r[i]) w5_r[i] <= (q > 42'd32768) ? 16'h8000 : 16'(-q);
        else         w5_r[i] <= (q > 42'd32767) ? 16'h7fff : q[15:0];
      end
    end
  end

  // stage 6: largest magnitude
  logic [3:0][15:0] mg;
  logic [15:0] mx01, mx23, mx;
  always_comb begin
    for (int i = 0; i < 4; i++) mg[i] = mag16(w5_r[i]);
    mx01 = (mg[0] > mg[1]) ? mg[0] : mg[1];
    mx23 = (mg[2] > mg[3]) ? mg[2] : mg[3];
    mx   = (mx01 > mx23) ? mx01 : mx23;
  end

  logic [3:0][15:0] w6_r, mg6_r;
  logic [15:0] lg6_r;
  logic        lm6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      w6_r  <= w5_r;
      mg6_r <= mg;
      lg6_r <= mx;
      lm6_r <= mx > 16'(lim_r);
    end
  end

  // stage 7: numerators, then the divider pipe
  div_t dv_r [QW+1];
  logic [QW:0] dv_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        dv_r[0].rem[i] <= NW'(mg6_r[i]) * NW'(lim_r);
        dv_r[0].quo[i] <= '0;
        dv_r[0].neg[i] <= w6_r[i][15];
      end
      dv_r[0].w       <= w6_r;
      dv_r[0].largest <= lg6_r;
      dv_r[0].limited <= lm6_r;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    always_ff @(posedge clk) begin
      div_t        nx;
      logic [NW:0] d;
      if (en) begin
        nx = dv_r[j];
        d  = (NW+1)'(dv_r[j].largest) << K;
        for (int i = 0; i < 4; i++) begin
          if ((NW+1)'(dv_r[j].rem[i]) >= d) begin
            nx.rem[i]    = NW'((NW+1)'(dv_r[j].rem[i]) - d);
            nx.quo[i][K] = 1'b1;
          end
        end
        dv_r[j+1] <= nx;
      end
    end
  end

  // output register
  logic [3:0][15:0] res;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dv_r[QW].limited)
        res[i] = dv_r[QW].neg[i] ? 16'(-{1'b0, dv_r[QW].quo[i]})
                                 : {1'b0, dv_r[QW].quo[i]};
      else
        res[i] = dv_r[QW].w[i];
    end
  end

  logic [3:0][15:0] o_r;
  logic             ol_r;
  always_ff @(posedge clk) begin
    if (en) begin
      o_r  <= res;
      ol_r <= dv_r[QW].limited;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      dv_v_r  <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r     <= {v_r[NST-2:0], in_cmd.valid};
      dv_v_r  <= {dv_v_r[QW-1:0], v_r[NST-1]};
      out_v_r <= dv_v_r[QW];
    end
  end

  assign out_rpm.valid           = out_v_r;
  assign out_rpm.right_front_rpm = o_r[0];
  assign out_rpm.left_front_rpm  = o_r[1];
  assign out_rpm.left_rear_rpm   = o_r[2];
  assign out_rpm.right_rear_rpm  = o_r[3];
  assign out_rpm.speed_limited   = ol_r;

  a_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_rpm.valid |-> (mag16(o_r[0]) <= 16'(lim_r)) && (mag16(o_r[1]) <= 16'(lim_r))
                   && (mag16(o_r[2]) <= 16'(lim_r)) && (mag16(o_r[3]) <= 16'(lim_r)))
    else $error("wheel speed above limit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_rpm.valid && (dv_v_r == '0))
    else $error("pipe not empty after reset");

  a_limited_has_max: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v_r[0] && dv_r[0].limited) |-> (dv_r[0].largest > 16'(lim_r)))
    else $error("limit flag without oversize wheel");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for mecanum_wheel_speed_mixer: clamps, mixing, rpm scaling,
// saturation and limit scaling checked word by word against an in-bench predictor.
// Depends on mwm_pkg, the channel interfaces in mwm_if.sv and the mixer RTL.
module tb
  import mwm_pkg::*;
();

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [15:0] rf;
    logic signed [15:0] lf;
    logic signed [15:0] lr;
    logic signed [15:0] rr;
    logic               limited;
  } wheel_set_t;

  class wheel_scoreboard;
    bit [14:0] lim_sx, lim_fw, lim_turn, lim_wheel;
    bit signed [31:0] rot_front, rot_rear;
    bit [31:0] rpm_ratio;
    wheel_set_t expected_q[$];
    int errors;
    int checked;
    int limited_seen;

    function void load_defaults();
      lim_sx = RST_MAX_SIDEWAYS;
      lim_fw = RST_MAX_FORWARD;
      lim_turn = RST_MAX_TURN;
      rot_front = RST_FRONT_ROT;
      rot_rear = RST_REAR_ROT;
      rpm_ratio = RST_RPM_RATIO;
      lim_wheel = RST_MAX_WHEEL;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_MAX_SIDEWAYS: lim_sx = d[14:0];
        REG_MAX_FORWARD:  lim_fw = d[14:0];
        REG_MAX_TURN:     lim_turn = d[14:0];
        REG_FRONT_ROT:    rot_front = d;
        REG_REAR_ROT:     rot_rear = d;
        REG_RPM_RATIO:    rpm_ratio = d;
        REG_MAX_WHEEL:    lim_wheel = d[14:0];
        default: ;
      endcase
    endfunction

    function longint clamp_speed(logic signed [15:0] v, bit [14:0] lim);
      longint sv;
      longint l;
      sv = v;
      l = lim;
      if (sv > l) return l;
      if (sv < -l) return -l;
      return sv;
    endfunction

    function longint sum_to_rpm(longint s);
      bit neg;
      longint unsigned m, a, b, x, q;
      neg = s < 0;
      m = neg ? -s : s;
      a = m >> 24;
      b = m & 64'hFF_FFFF;
      x = a * rpm_ratio + ((b * rpm_ratio) >> 24);
      q = x >> 16;
      if (neg) begin
        if (q > 32768) q = 32768;
        return -longint'(q);
      end
      if (q > 32767) q = 32767;
      return longint'(q);
    endfunction

    function void note_command(logic signed [15:0] vx, logic signed [15:0] vy,
                               logic signed [15:0] vw);
      longint cx, cy, cw, tf, tr, largest, m;
      longint w[4];
      wheel_set_t e;
      cx = clamp_speed(vx, lim_sx) * 65536;
      cy = clamp_speed(vy, lim_fw) * 65536;
      cw = clamp_speed(vw, lim_turn);
      tf = cw * longint'(rot_front);
      tr = cw * longint'(rot_rear);
      w[0] = sum_to_rpm(-cx - cy + tf);
      w[1] = sum_to_rpm(cx - cy + tf);
      w[2] = sum_to_rpm(cx + cy + tr);
      w[3] = sum_to_rpm(-cx + cy + tr);
      largest = 0;
      for (int i = 0; i < 4; i++) begin
        m = w[i] < 0 ? -w[i] : w[i];
        if (m > largest) largest = m;
      end
      e.limited = largest > longint'(lim_wheel);
      if (e.limited)
        for (int i = 0; i < 4; i++) w[i] = (w[i] * longint'(lim_wheel)) / largest;
      e.rf = w[0][15:0];
      e.lf = w[1][15:0];
      e.lr = w[2][15:0];
      e.rr = w[3][15:0];
      expected_q.push_back(e);
    endfunction

    function void check_result(wheel_set_t act);
      wheel_set_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected wheel word rf=%0d lf=%0d lr=%0d rr=%0d lim=%0b", $time,
                 act.rf, act.lf, act.lr, act.rr, act.limited);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (e.limited) limited_seen++;
      if (act.rf !== e.rf) begin
        $display("%0t: right_front_rpm exp %0d act %0d", $time, e.rf, act.rf);
        errors++;
      end
      if (act.lf !== e.lf) begin
        $display("%0t: left_front_rpm exp %0d act %0d", $time, e.lf, act.lf);
        errors++;
      end
      if (act.lr !== e.lr) begin
        $display("%0t: left_rear_rpm exp %0d act %0d", $time, e.lr, act.lr);
        errors++;
      end
      if (act.rr !== e.rr) begin
        $display("%0t: right_rear_rpm exp %0d act %0d", $time, e.rr, act.rr);
        errors++;
      end
      if (act.limited !== e.limited) begin
        $display("%0t: speed_limited exp %0b act %0b", $time, e.limited, act.limited);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  mwm_cmd_if in_cmd();
  mwm_rpm_if out_rpm();

  mecanum_wheel_speed_mixer i_dut (
    .clk(clk), .rst_n(rst_n), .in_cmd(in_cmd.sink), .out_rpm(out_rpm.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  wheel_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int sent_words = 0;

  initial begin
    in_cmd.valid = 1'b0;
    in_cmd.sideways_speed = '0;
    in_cmd.forward_speed = '0;
    in_cmd.turn_rate = '0;
    out_rpm.ready = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_rpm.ready <= 1'b0;
    end else begin
      out_rpm.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    wheel_set_t act;
    if (rst_n && in_cmd.valid && in_cmd.ready)
      sb.note_command(in_cmd.sideways_speed, in_cmd.forward_speed, in_cmd.turn_rate);
    if (rst_n && out_rpm.valid && out_rpm.ready) begin
      act.rf = out_rpm.right_front_rpm;
      act.lf = out_rpm.left_front_rpm;
      act.lr = out_rpm.left_rear_rpm;
      act.rr = out_rpm.right_rear_rpm;
      act.limited = out_rpm.speed_limited;
      sb.check_result(act);
    end
  end

  task automatic send_cmd(logic signed [15:0] vx, logic signed [15:0] vy,
                          logic signed [15:0] vw);
    in_cmd.valid <= 1'b1;
    in_cmd.sideways_speed <= vx;
    in_cmd.forward_speed <= vy;
    in_cmd.turn_rate <= vw;
    @(posedge clk);
    while (!in_cmd.ready) @(posedge clk);
    sent_words++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    in_cmd.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, d);
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_speed(bit [14:0] lim);
    int l;
    l = lim;
    case ($urandom_range(9))
      0, 1, 2: return 16'($urandom());
      3: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      4: return 16'($urandom_range(1) ? l : -l);
      default: return 16'($urandom_range(0, 2 * l + 2) - l - 1);
    endcase
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++)
      send_cmd(pick_speed(sb.lim_sx), pick_speed(sb.lim_fw), pick_speed(sb.lim_turn));
  endtask

  initial begin
    sb.load_defaults();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, field extremes, pure axes, saturation, limit scaling
    send_cmd(0, 0, 0);
    send_cmd(16'sh7FFF, 0, 0);
    send_cmd(16'sh8000, 0, 0);
    send_cmd(0, 16'sh7FFF, 0);
    send_cmd(0, 16'sh8000, 0);
    send_cmd(0, 0, 16'sh7FFF);
    send_cmd(0, 0, 16'sh8000);
    send_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_cmd(16'sh8000, 16'sh8000, 16'sh8000);
    send_cmd(-1, -1, -1);
    send_cmd(1, 1, 1);
    send_cmd(3300, -3300, 300);
    go_idle();
    write_cfg(REG_MAX_SIDEWAYS, 32'h7FFF);
    write_cfg(REG_MAX_FORWARD, 32'h7FFF);
    write_cfg(REG_MAX_TURN, 32'h7FFF);
    write_cfg(REG_FRONT_ROT, 32'h7FFF_FFFF);
    write_cfg(REG_REAR_ROT, 32'h8000_0000);
    write_cfg(REG_RPM_RATIO, 32'hFFFF_FFFF);
    write_cfg(REG_MAX_WHEEL, 32'h7FFF);
    write_cfg(REG_UNUSED, 32'h0000_0005);
    send_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_cmd(16'sh8000, 16'sh8000, 16'sh8000);
    send_cmd(16'sh8000, 16'sh7FFF, 16'sh8000);
    send_cmd(100, -100, 0);
    go_idle();
    write_cfg(REG_MAX_WHEEL, 32'h0);
    send_cmd(500, 200, 10);
    send_cmd(0, 0, 0);
    go_idle();
    write_cfg(REG_MAX_WHEEL, 32'h1);
    send_cmd(500, -200, -10);
    send_cmd(16'sh8000, 0, 0);

    // random, several settings, idle patterns rotate
    for (int k = 0; k < 6; k++) begin
      go_idle();
      case (k % 3)
        0: begin send_idle_pct = 27; recv_idle_pct = 80; end
        1: begin send_idle_pct = 80; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (k)
        0: begin
          write_cfg(REG_MAX_SIDEWAYS, 32'(RST_MAX_SIDEWAYS));
          write_cfg(REG_MAX_FORWARD, 32'(RST_MAX_FORWARD));
          write_cfg(REG_MAX_TURN, 32'(RST_MAX_TURN));
          write_cfg(REG_FRONT_ROT, RST_FRONT_ROT);
          write_cfg(REG_REAR_ROT, RST_REAR_ROT);
          write_cfg(REG_RPM_RATIO, RST_RPM_RATIO);
          write_cfg(REG_MAX_WHEEL, 32'(RST_MAX_WHEEL));
        end
        1: begin
          write_cfg(REG_MAX_SIDEWAYS, 32'h0);
          write_cfg(REG_MAX_FORWARD, 32'h0);
          write_cfg(REG_MAX_TURN, 32'h0);
          write_cfg(REG_RPM_RATIO, 32'h0);
        end
        default: begin
          write_cfg(REG_MAX_SIDEWAYS, $urandom());
          write_cfg(REG_MAX_FORWARD, $urandom());
          write_cfg(REG_MAX_TURN, $urandom_range(0, 2000));
          write_cfg(REG_FRONT_ROT, $urandom_range(0, 3 << 20) - (3 << 19));
          write_cfg(REG_REAR_ROT, (k == 5) ? $urandom() : $urandom_range(0, 1 << 21));
          write_cfg(REG_RPM_RATIO, (k == 4) ? $urandom() : $urandom_range(0, 1 << 18));
          write_cfg(REG_MAX_WHEEL, $urandom_range(1, 32767));
        end
      endcase
      if (k == 2) begin
        hold_left = 400;
        random_burst(100);
      end
      random_burst(300);
    end

    go_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d command words, checked %0d wheel words (%0d speed limited),",
             sent_words, sb.checked, sb.limited_seen);
    $display("over default, zero, extreme and random register settings with idle mixes.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mwm_pkg.sv
rtl/mwm_if.sv
rtl/mecanum_wheel_speed_mixer.sv
dv/tb.sv
